// ----- sv/framed_packet_receiver_macros.svh -----
// assertion macros for the framed packet receiver
// expect clk and rst_n in the scope of the module that uses them
`ifndef FRAMED_PACKET_RECEIVER_MACROS_SVH
`define FRAMED_PACKET_RECEIVER_MACROS_SVH

// same-cycle implication
`define FPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/fpr_pkg.sv -----
// shared types and constants for the framed packet receiver
// no dependencies
`timescale 1ns / 1ps

package fpr_pkg;

  localparam int PAYLOAD_DEPTH = 256;
  localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
  localparam int POS_W         = 9;
  localparam int NUM_HDR       = 4;

  localparam logic [POS_W-1:0] HDR_LEN    = POS_W'(4);
  localparam logic [POS_W-1:0] DATA_START = POS_W'(5);

  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [2:0] ST_BUSY     = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_CSUM_BAD = 3'd2;
  localparam logic [2:0] ST_HDR_BAD  = 3'd3;
  localparam logic [2:0] ST_IGNORED  = 3'd4;
  localparam logic [2:0] ST_RELEASED = 3'd5;
  localparam logic [2:0] ST_READ     = 3'd6;
  localparam logic [2:0] ST_TOO_LONG = 3'd7;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] frame_length;
    logic [7:0] read_data;
    logic       frame_held;
  } out_word_t;

endpackage

// ----- sv/framed_packet_receiver.sv -----
// framed packet receiver: header check, length, payload store, additive checksum
// depends on fpr_pkg and framed_packet_receiver_macros.svh
//
// channel   direction  handshake             payload
// in_       input      in_valid / in_ready   fpr_pkg::in_word_t
// out_      output     out_valid / out_ready fpr_pkg::out_word_t
// cfg_      input      cfg_we                cfg_index, cfg_wdata (header bytes)
//
// one word accepted per cycle while in_ready is high; its result goes through the staging register
// beside the payload memory's registered read port, and then through the output register
// a staging register and the output register hold two results, so input keeps flowing
// for one word after the output stalls; no clearing pass, ready right after reset
// synchronous active-low reset clears frame state and header registers
`timescale 1ns / 1ps
`include "framed_packet_receiver_macros.svh"

module framed_packet_receiver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fpr_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fpr_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata
);
  import fpr_pkg::*;

  logic [7:0]       hdr_r [NUM_HDR];
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic             held_r, held_nxt;

  logic [7:0]       mem [PAYLOAD_DEPTH];
  logic [7:0]       mem_q_r;
  logic             mem_we;
  logic             mem_re;
  logic [ADDR_W-1:0] wr_addr;
  logic [POS_W-1:0] pos_off;
  logic [POS_W-1:0] frame_end;
  logic [2:0]       status;

  logic             s1_v_r;
  logic [2:0]       s1_status_r;
  logic [7:0]       s1_len_r;
  logic             s1_held_r;
  logic             s1_rd_r;
  logic             s1_adv;

  logic             out_valid_r;
  out_word_t        out_data_r;
  logic             accept;

  assign s1_adv    = s1_v_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_v_r || s1_adv;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign pos_off   = pos_r - DATA_START;
  assign wr_addr   = pos_off[ADDR_W-1:0];
  assign frame_end = DATA_START + {1'b0, len_r};

  // header registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_HDR; i++) begin
        hdr_r[i] <= '0;
      end
    end else if (cfg_we) begin
      hdr_r[cfg_index] <= cfg_wdata;
    end
  end

  // frame state update for the accepted word
  always_comb begin
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    sum_nxt  = sum_r;
    held_nxt = held_r;
    status   = ST_IGNORED;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    unique case (in_data.command)
      CMD_BYTE: begin
        if (held_r) begin
          status = ST_IGNORED;
        end else if (pos_r < HDR_LEN) begin
          if (in_data.rx_byte != hdr_r[pos_r[1:0]]) begin
            pos_nxt = '0;
            len_nxt = '0;
            sum_nxt = '0;
            status  = ST_HDR_BAD;
          end else begin
            pos_nxt = pos_r + POS_W'(1);
            status  = ST_BUSY;
          end
        end else if (pos_r == HDR_LEN) begin
          if ({1'b0, in_data.rx_byte} > POS_W'(PAYLOAD_DEPTH)) begin
            pos_nxt = '0;
            len_nxt = '0;
            sum_nxt = '0;
            status  = ST_TOO_LONG;
          end else begin
            len_nxt = in_data.rx_byte;
            sum_nxt = '0;
            pos_nxt = DATA_START;
            status  = ST_BUSY;
          end
        end else if (pos_r >= frame_end) begin
          if (in_data.rx_byte == sum_r) begin
            held_nxt = 1'b1;
            pos_nxt  = '0;
            sum_nxt  = '0;
            status   = ST_OK;
          end else begin
            pos_nxt = '0;
            len_nxt = '0;
            sum_nxt = '0;
            status  = ST_CSUM_BAD;
          end
        end else begin
          mem_we  = 1'b1;
          sum_nxt = sum_r + in_data.rx_byte;
          pos_nxt = pos_r + POS_W'(1);
          status  = ST_BUSY;
        end
      end
      CMD_RELEASE: begin
        held_nxt = 1'b0;
        pos_nxt  = '0;
        len_nxt  = '0;
        sum_nxt  = '0;
        status   = ST_RELEASED;
      end
      CMD_READ: begin
        mem_re = {1'b0, in_data.read_index} < POS_W'(PAYLOAD_DEPTH);
        status = ST_READ;
      end
      default: begin
        status = ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      len_r  <= '0;
      sum_r  <= '0;
      held_r <= 1'b0;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      sum_r  <= sum_nxt;
      held_r <= held_nxt;
    end
  end

  // payload memory, at most one write or one read per accepted word
  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      mem[wr_addr] <= in_data.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && mem_re) begin
      mem_q_r <= mem[in_data.read_index[ADDR_W-1:0]];
    end
  end

  // staging register alongside the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= status;
      s1_len_r    <= len_nxt;
      s1_held_r   <= held_nxt;
      s1_rd_r     <= mem_re;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.status       <= s1_status_r;
      out_data_r.frame_length <= s1_len_r;
      out_data_r.read_data    <= s1_rd_r ? mem_q_r : 8'd0;
      out_data_r.frame_held   <= s1_held_r;
    end
  end

  `FPR_ASSERT_NOW(a_pos_in_frame, 1'b1, pos_r <= frame_end, "position beyond checksum byte")
  `FPR_ASSERT_NOW(a_held_idle, held_r, pos_r == '0 && sum_r == '0, "held frame with live state")
  `FPR_ASSERT_NOW(a_full_stall, s1_v_r && out_valid_r && !out_ready, !in_ready,
                  "input taken with both result slots full")
  `FPR_ASSERT_NEXT(a_accept_stage, accept, s1_v_r, "accepted word lost before staging")
  `FPR_ASSERT_NEXT(a_no_mem_clash, accept && mem_we, !(accept && mem_re) || s1_v_r,
                   "memory read and write tracking broken")

endmodule

// ----- tb/tb_framed_packet_receiver.sv -----
// testbench for framed_packet_receiver: directed frames and random frame traffic
// checked word by word against an in-bench model; depends on fpr_pkg and the rtl
`timescale 1ns / 1ps

module tb_framed_packet_receiver;
  import fpr_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam logic [1:0] REG_HEADER_0 = 2'd0;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_PAUSE  = 8;
  localparam int LONG_STALL   = 150;
  localparam int PHASE_WORDS  = 120;

  typedef enum {FRAME_GOOD, FRAME_BAD_HEADER, FRAME_BAD_SUM, FRAME_ABANDON} frame_kind_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_we    = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;

  // model state
  logic [7:0] hdr_exp [NUM_HDR];
  logic [POS_W-1:0] rx_pos;
  logic [7:0] rx_len;
  logic [7:0] rx_sum;
  logic       held_frame;
  logic [7:0] payload_mem [PAYLOAD_DEPTH];
  bit         payload_written [PAYLOAD_DEPTH];
  int         written_index [$];

  out_word_t  expected_results [$];
  int         useful_words  = 0;
  int         mismatches    = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         cycles        = 0;
  logic       long_stall    = 1'b0;
  event       long_stall_go;

  framed_packet_receiver DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void restart_hunt();
    rx_pos = '0;
    rx_len = '0;
    rx_sum = '0;
  endfunction

  function automatic out_word_t predict_result(input in_word_t w);
    out_word_t r;
    int idx;
    r = '0;
    case (w.command)
      CMD_BYTE: begin
        if (held_frame) begin
          r.status = ST_IGNORED;
        end else if (rx_pos < HDR_LEN) begin
          if (w.rx_byte != hdr_exp[rx_pos[1:0]]) begin
            restart_hunt();
            r.status = ST_HDR_BAD;
          end else begin
            rx_pos = rx_pos + POS_W'(1);
            r.status = ST_BUSY;
          end
        end else if (rx_pos == HDR_LEN) begin
          if (int'(w.rx_byte) > PAYLOAD_DEPTH) begin
            restart_hunt();
            r.status = ST_TOO_LONG;
          end else begin
            rx_len = w.rx_byte;
            rx_sum = '0;
            rx_pos = DATA_START;
            r.status = ST_BUSY;
          end
        end else if (int'(rx_pos) >= int'(DATA_START) + int'(rx_len)) begin
          if (w.rx_byte == rx_sum) begin
            held_frame = 1'b1;
            rx_pos = '0;
            rx_sum = '0;
            r.status = ST_OK;
          end else begin
            restart_hunt();
            r.status = ST_CSUM_BAD;
          end
        end else begin
          idx = (int'(rx_pos) - int'(DATA_START)) & 255;
          payload_mem[idx] = w.rx_byte;
          if (!payload_written[idx]) begin
            payload_written[idx] = 1'b1;
            written_index.push_back(idx);
          end
          rx_sum = rx_sum + w.rx_byte;
          rx_pos = rx_pos + POS_W'(1);
          r.status = ST_BUSY;
        end
      end
      CMD_RELEASE: begin
        held_frame = 1'b0;
        restart_hunt();
        r.status = ST_RELEASED;
      end
      CMD_READ: begin
        if (int'(w.read_index) < PAYLOAD_DEPTH) r.read_data = payload_mem[w.read_index];
        r.status = ST_READ;
      end
      default: begin
        r.status = ST_IGNORED;
      end
    endcase
    r.frame_length = rx_len;
    r.frame_held   = held_frame;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 100)
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
  endtask

  // result side: random ready, long hold when asked, compare each word
  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result status", got.status, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
          if (got.frame_length != want.frame_length)
            report_mismatch("frame_length", got.frame_length, want.frame_length);
          if (got.read_data != want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
          if (got.frame_held != want.frame_held)
            report_mismatch("frame_held", got.frame_held, want.frame_held);
        end
      end
      if (long_stall) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial forever begin
    @(long_stall_go);
    long_stall <= 1'b1;
    repeat (LONG_STALL) @(posedge clk);
    long_stall <= 1'b0;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_word(input in_word_t w);
    out_word_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    want = predict_result(w);
    expected_results.push_back(want);
    if (want.status != ST_IGNORED) useful_words++;
  endtask

  task automatic send_command(input logic [1:0] cmd, input logic [7:0] b,
                              input logic [7:0] idx);
    in_word_t w;
    w.command    = cmd;
    w.rx_byte    = b;
    w.read_index = idx;
    send_word(w);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_command(CMD_BYTE, b, 8'($urandom));
  endtask

  task automatic send_release();
    send_command(CMD_RELEASE, 8'($urandom), 8'($urandom));
  endtask

  task automatic send_unused();
    send_command(CMD_UNUSED, 8'($urandom), 8'($urandom));
  endtask

  // reads only entries already written
  task automatic send_read();
    if (written_index.size() == 0) begin
      send_unused();
    end else begin
      send_command(CMD_READ, 8'($urandom),
                   8'(written_index[$urandom_range(0, written_index.size() - 1)]));
    end
  endtask

  task automatic send_frame(input frame_kind_t kind, input int len);
    int cut;
    logic [7:0] sum;
    logic [7:0] b;
    sum = '0;
    cut = $urandom_range(0, NUM_HDR - 1);
    for (int k = 0; k < NUM_HDR; k++) begin
      if (kind == FRAME_BAD_HEADER && k == cut) begin
        send_byte(hdr_exp[k] ^ 8'($urandom_range(1, 255)));
        return;
      end
      send_byte(hdr_exp[k]);
    end
    send_byte(8'(len));
    cut = $urandom_range(0, len);
    for (int k = 0; k < len; k++) begin
      if (kind == FRAME_ABANDON && k == cut) begin
        send_release();
        return;
      end
      b = 8'($urandom);
      sum = sum + b;
      send_byte(b);
    end
    if (kind == FRAME_ABANDON) send_release();
    else if (kind == FRAME_BAD_SUM) send_byte(sum ^ 8'($urandom_range(1, 255)));
    else send_byte(sum);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // only called with the block drained
  task automatic set_headers(input logic [7:0] h0, input logic [7:0] h1,
                             input logic [7:0] h2, input logic [7:0] h3);
    logic [7:0] v [NUM_HDR];
    v = '{h0, h1, h2, h3};
    for (int i = 0; i < NUM_HDR; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= REG_HEADER_0 + 2'(i);
      cfg_wdata <= v[i];
      hdr_exp[i] = v[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // header registers still at reset value zero
  task automatic test_reset_headers();
    send_unused();
    send_release();
    send_frame(FRAME_GOOD, 0);
    send_byte(8'hFF);
    send_release();
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h80);
    // checksum wraps
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFE);
    send_command(CMD_READ, 8'h00, 8'h01);
    send_command(CMD_READ, 8'hFF, 8'h00);
    send_release();
    send_frame(FRAME_BAD_SUM, 1);
    wait_drained();
  endtask

  task automatic test_header_extremes();
    set_headers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_frame(FRAME_GOOD, 2);
    send_release();
    send_frame(FRAME_BAD_HEADER, 0);
    wait_drained();
    set_headers(8'h00, 8'hFF, 8'h00, 8'hFF);
    send_frame(FRAME_ABANDON, 3);
    send_frame(FRAME_GOOD, 0);
    send_unused();
    send_release();
    wait_drained();
  endtask

  task automatic test_longest_frame();
    set_headers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    send_frame(FRAME_GOOD, 255);
    send_command(CMD_READ, 8'h00, 8'd254);
    send_command(CMD_READ, 8'h00, 8'd128);
    send_command(CMD_READ, 8'h00, 8'd127);
    send_release();
    wait_drained();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    int target;
    int r;
    int len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    set_headers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    target = useful_words + PHASE_WORDS;
    while (useful_words < target) begin
      r = $urandom_range(0, 99);
      len = $urandom_range(0, 99);
      len = (len < 5) ? 0 : (len < 60) ? $urandom_range(1, 4) : $urandom_range(5, 24);
      if (held_frame) begin
        if (r < 45) send_read();
        else if (r < 55) send_byte(8'($urandom));
        else if (r < 60) send_unused();
        else send_release();
      end else begin
        if (r < 65) send_frame(FRAME_GOOD, len);
        else if (r < 73) send_frame(FRAME_BAD_HEADER, len);
        else if (r < 81) send_frame(FRAME_BAD_SUM, len);
        else if (r < 86) send_frame(FRAME_ABANDON, len);
        else if (r < 94) send_byte(8'($urandom));
        else if (r < 97) send_read();
        else send_unused();
      end
    end
    wait_drained();
  endtask

  // result side held off while words keep coming, so the block must stall its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_headers(8'hA5, 8'h5A, 8'h00, 8'hFF);
    -> long_stall_go;
    for (int i = 0; i < 5; i++) begin
      send_frame(FRAME_GOOD, 3);
      send_read();
      send_release();
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < NUM_HDR; i++) hdr_exp[i] = '0;
    held_frame = 1'b0;
    restart_hunt();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 21;
    recv_idle_pct = 67;
    test_reset_headers();
    test_header_extremes();
    test_longest_frame();
    test_random_traffic(21, 67);
    test_random_traffic(67, 21);
    test_backpressure();
    test_random_traffic(0, 0);
    wait_drained();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- framed_packet_receiver.f -----
+incdir+sv
sv/fpr_pkg.sv
sv/framed_packet_receiver.sv
tb/tb_framed_packet_receiver.sv
